### hw/rtl/ibge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibge_pkg
// Types and constants shared by the band equalizer modules.
// ----------------------------------------------------------------------------
package ibge_pkg;

  localparam int unsigned Bands = 26;
  localparam int unsigned Order = 2;
  localparam int unsigned NTaps = 2 * Order + 1;
  localparam int unsigned NHist = 2 * Order;
  localparam int unsigned BandW = (Bands > 1) ? $clog2(Bands) : 1;
  localparam int unsigned TapW  = $clog2(NTaps + 1);
  localparam int unsigned CoefAw = $clog2(Bands * NTaps);
  localparam int unsigned YhAw   = $clog2(Bands * NHist);
  localparam int unsigned XhW    = (NHist > 1) ? $clog2(NHist) : 1;

  typedef enum logic [1:0] {
    OpSample = 2'd0,
    OpWrFf   = 2'd1,
    OpWrFb   = 2'd2,
    OpWrGain = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         band;
    logic [2:0]         tap;
    logic signed [31:0] coefficient;
    logic [15:0]        gain;
    logic signed [15:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] filtered;
    logic               clipped;
  } out_beat_t;

  // datapath commands, one per cycle
  typedef enum logic [2:0] {
    CmdIdle,
    CmdWrite,   // store coefficient or gain from in beat, latch its sample
    CmdBandClr, // clear accumulator (and total if clr_total), load gain of band
    CmdRdFf,    // issue reads for feed-forward tap
    CmdRdFb,    // issue reads for feedback tap
    CmdBandEnd, // saturate band output, push history, add to total
    CmdFinish,  // shift input history, round and saturate total to output
    CmdClear    // zero the stores at band/tap after reset
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [BandW-1:0]   band;
    logic [TapW-1:0]    tap;
    logic               clr_total;
  } ctl_t;

  typedef struct packed {
    logic pipe_busy; // reads/multiplies still in flight
  } sts_t;

endpackage

### hw/rtl/ibge_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibge_ctrl
// Sequencer: walks bands and taps, issues datapath commands.
// ----------------------------------------------------------------------------
module ibge_ctrl import ibge_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_data_i,
  input  logic     out_busy_i,
  input  sts_t     sts_i,
  output ctl_t     ctl_o,
  output logic     done_o
);

  typedef enum logic [2:0] {
    StIdle, StBandStart, StFf, StFb, StDrain, StBandEnd, StFinish, StClear
  } state_e;

  state_e           state_q;
  logic [BandW-1:0] band_q;
  logic [TapW-1:0]  tap_q;
  logic             first_q;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    ctl_o = '0;
    ctl_o.cmd  = CmdIdle;
    ctl_o.band = band_q;
    ctl_o.tap  = tap_q;
    done_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o && in_data_i.operation != OpSample) begin
          ctl_o.cmd = CmdWrite;
        end
      end
      StBandStart: begin
        ctl_o.cmd = CmdBandClr;
        ctl_o.clr_total = first_q;
      end
      StFf:      ctl_o.cmd = CmdRdFf;
      StFb:      ctl_o.cmd = CmdRdFb;
      StBandEnd: ctl_o.cmd = CmdBandEnd;
      StFinish: begin
        // hold the total until the previous result has left
        if (!out_busy_i) begin
          ctl_o.cmd = CmdFinish;
          done_o = 1'b1;
        end
      end
      StClear:   ctl_o.cmd = CmdClear;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      band_q  <= '0;
      tap_q   <= '0;
      first_q <= 1'b0;
    end else begin
      case (state_q)
        StClear: begin
          if (tap_q == TapW'(NTaps - 1)) begin
            tap_q <= '0;
            if (band_q == BandW'(Bands - 1)) begin
              state_q <= StIdle;
            end else begin
              band_q <= band_q + 1'b1;
            end
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        StIdle: begin
          if (in_valid_i && in_ready_o && in_data_i.operation == OpSample) begin
            state_q <= StBandStart;
            band_q  <= '0;
            first_q <= 1'b1;
          end
        end
        StBandStart: begin
          first_q <= 1'b0;
          tap_q   <= '0;
          state_q <= StFf;
        end
        StFf: begin
          if (tap_q == TapW'(NTaps - 1)) begin
            tap_q   <= TapW'(1);
            state_q <= StFb;
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        StFb: begin
          if (tap_q == TapW'(NTaps - 1)) begin
            state_q <= StDrain;
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        StDrain: begin
          if (!sts_i.pipe_busy) state_q <= StBandEnd;
        end
        StBandEnd: begin
          if (band_q == BandW'(Bands - 1)) begin
            state_q <= StFinish;
          end else begin
            band_q  <= band_q + 1'b1;
            state_q <= StBandStart;
          end
        end
        StFinish: begin
          if (!out_busy_i) state_q <= StIdle;
        end
        default:  state_q <= StIdle;
      endcase
    end
  end

endmodule

### hw/rtl/ibge_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibge_dp
// Coefficient/history memories and one shared multiply-accumulate path.
// ----------------------------------------------------------------------------
module ibge_dp import ibge_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_beat_t           in_data_i,
  input  ctl_t               ctl_i,
  output sts_t               sts_o,
  output logic signed [15:0] filtered_o,
  output logic               clipped_o
);

  localparam int unsigned NCoef = Bands * NTaps;
  localparam int unsigned NYh   = Bands * NHist;

  // coefficient and band output stores, zeroed by the clearing pass after reset
  logic signed [31:0] ff_mem [NCoef];
  logic signed [31:0] fb_mem [NCoef];
  logic signed [31:0] yh_mem [NYh];
  logic [15:0]        gain_q [Bands];
  logic [XhW-1:0]     yptr_q [Bands];  // slot of the newest output of each band
  logic signed [15:0] xh_q [NHist];

  logic signed [15:0] x_q;      // current sample
  logic [15:0]        g_q;      // current band gain
  logic signed [63:0] acc_q, total_q;

  function automatic logic signed [63:0] rnd_sh(logic signed [63:0] v, int unsigned s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  // write and read addresses
  logic [CoefAw-1:0] wr_addr, rd_addr;
  assign wr_addr = CoefAw'(in_data_i.band * NTaps + in_data_i.tap);
  assign rd_addr = CoefAw'(ctl_i.band * NTaps + ctl_i.tap);

  logic wr_ok, wr_coef, clr;
  assign wr_ok   = (ctl_i.cmd == CmdWrite) && (in_data_i.band < 5'(Bands));
  assign wr_coef = wr_ok && (in_data_i.tap < 3'(NTaps));
  assign clr     = (ctl_i.cmd == CmdClear);

  always_ff @(posedge clk_i) begin
    if (clr) begin
      ff_mem[rd_addr] <= '0;
      fb_mem[rd_addr] <= '0;
    end else if (wr_coef) begin
      if (in_data_i.operation == OpWrFf) ff_mem[wr_addr] <= in_data_i.coefficient;
      if (in_data_i.operation == OpWrFb) fb_mem[wr_addr] <= in_data_i.coefficient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Bands; i++) gain_q[i] <= '0;
    end else if (wr_ok && in_data_i.operation == OpWrGain) begin
      gain_q[BandW'(in_data_i.band)] <= in_data_i.gain;
    end
  end

  // pipeline: S1 memory read, S2 coef*gain or a*y, S3 round, S4 beff*x, S5 acc
  logic               s1_v_q, s1_ff_q;
  logic signed [31:0] s1_c_q;
  logic signed [31:0] s1_h_q;      // y history or x sample
  logic               s2_v_q, s2_ff_q;
  logic signed [63:0] s2_p_q;
  logic signed [31:0] s2_h_q;
  logic               s3_v_q, s3_ff_q;
  logic signed [63:0] s3_t_q;      // rounded feedback term or beff
  logic signed [31:0] s3_h_q;
  logic               s4_v_q;
  logic signed [63:0] s4_t_q;

  logic rd_ff, rd_fb;
  assign rd_ff = (ctl_i.cmd == CmdRdFf);
  assign rd_fb = (ctl_i.cmd == CmdRdFb);

  // band output saturation
  logic signed [31:0] y_sat;
  always_comb begin
    if (acc_q > 64'sd2147483647)       y_sat = 32'sh7fffffff;
    else if (acc_q < -64'sd2147483648) y_sat = 32'sh80000000;
    else                               y_sat = acc_q[31:0];
  end

  // band output history kept as a ring per band
  logic [YhAw-1:0]    yb, yh_raddr, yh_waddr;
  logic [XhW-1:0]     yptr, yptr_nxt, back, slot;
  logic               yh_we;
  logic signed [31:0] yh_wdata;

  assign yb       = YhAw'(ctl_i.band * NHist);
  assign yptr     = yptr_q[ctl_i.band];
  assign yptr_nxt = (yptr == XhW'(NHist - 1)) ? '0 : yptr + 1'b1;
  // feedback tap c reads the output c-1 beats back from the newest
  assign back     = (ctl_i.tap == '0) ? '0 : XhW'(ctl_i.tap - 1'b1);
  assign slot     = (yptr >= back) ? yptr - back : yptr + XhW'(NHist) - back;
  assign yh_raddr = yb + YhAw'(slot);

  always_comb begin
    yh_we    = (ctl_i.cmd == CmdBandEnd);
    yh_waddr = yb + YhAw'(yptr_nxt);
    yh_wdata = y_sat;
    if (clr) begin
      yh_we    = (ctl_i.tap < TapW'(NHist));
      yh_waddr = yb + YhAw'(ctl_i.tap);
      yh_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (yh_we) yh_mem[yh_waddr] <= yh_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Bands; i++) yptr_q[i] <= '0;
    end else if (ctl_i.cmd == CmdBandEnd) begin
      yptr_q[ctl_i.band] <= yptr_nxt;
    end
  end

  logic signed [31:0] x_sel;
  always_comb begin
    x_sel = 32'(x_q);
    if (ctl_i.tap != '0) x_sel = 32'(xh_q[XhW'(ctl_i.tap - 1'b1)]);
  end

  always_ff @(posedge clk_i) begin
    if (rd_ff) begin
      s1_c_q <= ff_mem[rd_addr];
      s1_h_q <= x_sel;
    end else begin
      s1_c_q <= fb_mem[rd_addr];
      s1_h_q <= yh_mem[yh_raddr];
    end
  end

  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p, xmul_p;
  assign mul_b  = s1_ff_q ? $signed({16'd0, g_q}) : s1_h_q;
  assign mul_p  = s1_c_q * mul_b;
  assign xmul_p = $signed(s3_t_q[31:0]) * $signed(s3_h_q[15:0]);

  logic signed [63:0] beff_r;
  logic signed [31:0] beff_s;
  always_comb begin
    beff_r = rnd_sh(s2_p_q, 15);
    if (beff_r > 64'sd2147483647)       beff_s = 32'sh7fffffff;
    else if (beff_r < -64'sd2147483648) beff_s = 32'sh80000000;
    else                                beff_s = beff_r[31:0];
  end

  always_ff @(posedge clk_i) begin
    s2_p_q  <= mul_p;
    s2_h_q  <= s1_h_q;
    s2_ff_q <= s1_ff_q;
    s3_t_q  <= s2_ff_q ? 64'(beff_s) : -rnd_sh(s2_p_q, 24);
    s3_h_q  <= s2_h_q;
    s3_ff_q <= s2_ff_q;
    s4_t_q  <= s3_ff_q ? rnd_sh(xmul_p, 15) : s3_t_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0; s4_v_q <= 1'b0;
      s1_ff_q <= 1'b0;
    end else begin
      s1_v_q  <= rd_ff || rd_fb;
      s1_ff_q <= rd_ff;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
    end
  end

  assign sts_o.pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q || rd_ff || rd_fb;

  logic signed [63:0] tot_r;
  assign tot_r = rnd_sh(total_q, 9);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NHist; i++) xh_q[i] <= '0;
      acc_q      <= '0;
      total_q    <= '0;
      x_q        <= '0;
      g_q        <= '0;
      filtered_o <= '0;
      clipped_o  <= 1'b0;
    end else begin
      if (ctl_i.cmd == CmdBandClr) acc_q <= '0;
      else if (s4_v_q) acc_q <= acc_q + s4_t_q;
      case (ctl_i.cmd)
        CmdWrite: x_q <= in_data_i.sample;
        CmdBandClr: begin
          g_q <= gain_q[ctl_i.band];
          if (ctl_i.clr_total) total_q <= '0;
        end
        CmdBandEnd: total_q <= total_q + 64'(y_sat);
        CmdFinish: begin
          for (int k = NHist - 1; k > 0; k--) xh_q[k] <= xh_q[k - 1];
          xh_q[0] <= x_q;
          if (tot_r > 64'sd32767) begin
            filtered_o <= 16'sh7fff; clipped_o <= 1'b1;
          end else if (tot_r < -64'sd32768) begin
            filtered_o <= 16'sh8000; clipped_o <= 1'b1;
          end else begin
            filtered_o <= tot_r[15:0]; clipped_o <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/iir_band_gain_equalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_band_gain_equalizer
// Bank of direct-form-I IIR band filters with per-band gain, summed output.
// ----------------------------------------------------------------------------
// After reset a clearing pass walks every band and tap and zeroes the
// coefficient and history stores, with the input held off. Write beats
// (coefficients, gains) produce no result. A sample beat walks all bands
// through one shared, pipelined multiply path: per band a setup step, reads
// for 2*Order+1 feed-forward and 2*Order feedback taps, a drain of the
// pipeline and a closing step. The result becomes valid in the same cycle
// that the next beat can be taken; a new sample is not taken before the last
// one is through. The output register lets the next beat in while a result
// waits; only the final step of the following sample stalls until that
// result is taken.
module iir_band_gain_equalizer import ibge_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  ctl_t ctl;
  sts_t sts;
  logic done;
  logic out_v_q;
  logic signed [15:0] filt;
  logic clip;

  // data path sees the input beat unchanged; it latches the sample on every write cmd
  in_beat_t dp_in;
  always_comb begin
    dp_in = in_data_i;
  end

  ibge_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_busy_i(out_v_q), .sts_i(sts), .ctl_o(ctl), .done_o(done)
  );

  // sample beats also latch x via a write cmd variant
  ctl_t ctl_dp;
  always_comb begin
    ctl_dp = ctl;
    if (in_valid_i && in_ready_o && in_data_i.operation == OpSample) ctl_dp.cmd = CmdWrite;
  end

  ibge_dp u_dp (
    .clk_i, .rst_ni, .in_data_i(dp_in), .ctl_i(ctl_dp), .sts_o(sts),
    .filtered_o(filt), .clipped_o(clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (done) out_v_q <= 1'b1;
    else if (out_ready_i) out_v_q <= 1'b0;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o.filtered = filt;
  assign out_data_o.clipped  = clip;

endmodule

### hw/rtl/ibge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibge_checker
// Port-level checks for the band equalizer.
// ----------------------------------------------------------------------------
module ibge_checker import ibge_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_beat_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.operation != OpSample && !out_valid_o
      |=> !out_valid_o)
    else $error("write beat produced a result");

  a_clip_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.filtered == 16'sh7fff || out_data_o.filtered == 16'sh8000)
    else $error("clipped without saturated value");

endmodule

bind iir_band_gain_equalizer ibge_checker u_ibge_checker (.*);
